// ----- sv/scan_code_to_ascii_decoder_macros.svh -----
// assertion macros used by the scan code decoder top level
`ifndef SCAN_CODE_TO_ASCII_DECODER_MACROS_SVH
`define SCAN_CODE_TO_ASCII_DECODER_MACROS_SVH

// same-cycle implication, checked on every clock out of reset
`define SCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// next-cycle implication, checked on every clock out of reset
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

// ----- sv/sca_pkg.sv -----
// types, scan code constants and character tables for the scan code decoder
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [6:0] KEY_MASK    = 7'h7f;
    localparam logic [6:0] SC_LSHIFT   = 7'h2a;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_CAPSLOCK = 7'h3a;
    localparam logic [6:0] CHAR_NONE   = 7'h00;

    // modifier flags kept between words
    typedef struct packed {
        logic left_shift;
        logic right_shift;
        logic caps_lock;
    } mod_flags_t;

    // what one scan word does
    typedef struct packed {
        logic       emit;
        logic [6:0] code;
        mod_flags_t flags;
    } decode_result_t;

    // unshifted character for each make code, zero where there is none
    function automatic logic [6:0] base_map(input logic [6:0] key);
        logic [6:0] c;
        unique case (key)
            7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
            7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
            7'h0a: c = 7'h39;  7'h0b: c = 7'h30;  7'h0c: c = 7'h2d;  7'h0d: c = 7'h3d;
            7'h0e: c = 7'h08;  7'h0f: c = 7'h09;
            7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
            7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
            7'h18: c = 7'h6f;  7'h19: c = 7'h70;  7'h1a: c = 7'h5b;  7'h1b: c = 7'h5d;
            7'h1c: c = 7'h0a;  7'h1e: c = 7'h61;  7'h1f: c = 7'h73;
            7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
            7'h24: c = 7'h6a;  7'h25: c = 7'h6b;  7'h26: c = 7'h6c;  7'h27: c = 7'h3b;
            7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2b: c = 7'h5c;
            7'h2c: c = 7'h7a;  7'h2d: c = 7'h78;  7'h2e: c = 7'h63;  7'h2f: c = 7'h76;
            7'h30: c = 7'h62;  7'h31: c = 7'h6e;  7'h32: c = 7'h6d;  7'h33: c = 7'h2c;
            7'h34: c = 7'h2e;  7'h35: c = 7'h2f;  7'h39: c = 7'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic is_lower(input logic [6:0] c);
        return (c >= 7'h61) && (c <= 7'h7a);
    endfunction

    // shifted form of digits and punctuation, letters to upper case
    function automatic logic [6:0] shifted(input logic [6:0] c);
        logic [6:0] s;
        if (is_lower(c)) begin
            s = c - 7'h20;
        end
        else begin
            unique case (c)
                7'h30: s = 7'h29;  7'h31: s = 7'h21;  7'h32: s = 7'h40;  7'h33: s = 7'h23;
                7'h34: s = 7'h24;  7'h35: s = 7'h25;  7'h36: s = 7'h5e;  7'h37: s = 7'h26;
                7'h38: s = 7'h2a;  7'h39: s = 7'h28;  7'h2d: s = 7'h5f;  7'h3d: s = 7'h2b;
                7'h5b: s = 7'h7b;  7'h5d: s = 7'h7d;  7'h5c: s = 7'h7c;  7'h3b: s = 7'h3a;
                7'h27: s = 7'h22;  7'h2c: s = 7'h3c;  7'h2e: s = 7'h3e;  7'h2f: s = 7'h3f;
                7'h60: s = 7'h7e;
                default: s = c;
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sca_decode.sv -----
// combinational decode of one scan word against the current modifier flags
`timescale 1ns / 1ps
`default_nettype none

module sca_decode (
    input  wire logic [7:0]              scan_word,
    input  wire sca_pkg::mod_flags_t     flags,
    output sca_pkg::decode_result_t      result
);

    logic [6:0] key;
    logic       is_break;
    logic [6:0] base_c;
    logic [6:0] caps_c;

    assign key      = scan_word[6:0] & sca_pkg::KEY_MASK;
    assign is_break = (scan_word & sca_pkg::BREAK_BIT) != 8'h00;

    // table lookup, caps lock, then shift
    assign base_c = sca_pkg::base_map(key);
    assign caps_c = (flags.caps_lock && sca_pkg::is_lower(base_c)) ? base_c - 7'h20 : base_c;

    always_comb
    begin
        result.emit  = 1'b0;
        result.code  = (flags.left_shift || flags.right_shift) ? sca_pkg::shifted(caps_c)
                                                               : caps_c;
        result.flags = flags;
        if (is_break) begin
            // release: clear shift or toggle caps lock
            if (key == sca_pkg::SC_LSHIFT) begin
                result.flags.left_shift = 1'b0;
            end
            else if (key == sca_pkg::SC_RSHIFT) begin
                result.flags.right_shift = 1'b0;
            end
            else if (key == sca_pkg::SC_CAPSLOCK) begin
                result.flags.caps_lock = ~flags.caps_lock;
            end
        end
        else if (key == sca_pkg::SC_LSHIFT) begin
            result.flags.left_shift = 1'b1;
        end
        else if (key == sca_pkg::SC_RSHIFT) begin
            result.flags.right_shift = 1'b1;
        end
        else begin
            result.emit = base_c != sca_pkg::CHAR_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- sv/scan_code_to_ascii_decoder.sv -----
// set-1 scan code to ascii decoder, top level
// an accepted scan word is held in the input register, then decoded into the output register,
// from which the character is taken; a word waits in the input register while the output stalls
// throughput: one word per cycle unless the output stalls; input and output registers each hold one
// a word is decoded as it leaves the input register, which is when modifier flags update
// reset clears both valid bits and the shift and caps lock flags; payloads are not reset
`timescale 1ns / 1ps
`default_nettype none

`include "scan_code_to_ascii_decoder_macros.svh"

module scan_code_to_ascii_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] scan_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      ascii_char
);

    logic                    in_valid_reg;
    logic [7:0]              scan_reg;
    logic                    out_valid_reg;
    logic [6:0]              char_reg;
    sca_pkg::mod_flags_t     flags_reg;
    sca_pkg::decode_result_t dec;
    logic                    advance;

    // the input word moves on whenever the output slot is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    sca_decode u_decode (
        .scan_word (scan_reg),
        .flags     (flags_reg),
        .result    (dec)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            scan_reg <= scan_byte;
        end
    end

    // modifier flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= in_valid_reg && dec.emit;
            if (in_valid_reg) begin
                flags_reg <= dec.flags;
            end
        end
    end

    // output character register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && dec.emit) begin
            char_reg <= dec.code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;

    // a break word never produces a character
    `SCA_ASSERT_NEXT(a_break_silent, clk, rst_n,
        advance && in_valid_reg && scan_reg[7], !out_valid_reg)

    // left shift release leaves left shift clear
    `SCA_ASSERT_NEXT(a_lshift_clear, clk, rst_n,
        advance && in_valid_reg && scan_reg == {1'b1, sca_pkg::SC_LSHIFT},
        !flags_reg.left_shift)

    // caps lock release flips caps lock
    `SCA_ASSERT_NEXT(a_caps_toggle, clk, rst_n,
        advance && in_valid_reg && scan_reg == {1'b1, sca_pkg::SC_CAPSLOCK},
        flags_reg.caps_lock != $past(flags_reg.caps_lock))

    // a delivered character is never the empty code
    `SCA_ASSERT_SAME(a_char_nonzero, clk, rst_n,
        out_valid_reg, char_reg != sca_pkg::CHAR_NONE)

endmodule

`default_nettype wire
